FILE: rtl/core/mkd_pkg.sv
// mkd_pkg: types, constants and the letter lookup for the morse key decoder
// no dependencies; used by the result interface and every module of the block
package mkd_pkg;

	localparam int MAX_SYMBOLS = 8;
	localparam int SYM_CNT_W   = $clog2(MAX_SYMBOLS + 1);
	localparam int TIMER_W     = 16;
	localparam int CODE_W      = 7;
	localparam int REG_IDX_W   = 2;

	localparam logic [TIMER_W-1:0] TIMER_MAX          = '1;
	localparam logic [TIMER_W-1:0] DASH_THRESHOLD_RST = TIMER_W'(200);
	localparam logic [TIMER_W-1:0] LETTER_GAP_RST     = TIMER_W'(400);
	localparam logic [TIMER_W-1:0] SPACE_GAP_RST      = TIMER_W'(1000);
	localparam logic [CODE_W-1:0]  CODE_UNKNOWN       = CODE_W'(8'h3f);

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DASH_THRESHOLD = 2'd0,
		REG_LETTER_GAP     = 2'd1,
		REG_SPACE_GAP      = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		SYM_NONE = 2'd0,
		SYM_DOT  = 2'd1,
		SYM_DASH = 2'd2
	} symbol_t;

	typedef struct packed {
		logic [TIMER_W-1:0] dash_threshold;
		logic [TIMER_W-1:0] letter_gap;
		logic [TIMER_W-1:0] space_gap;
	} cfg_t;

	typedef struct packed {
		logic                   key_was_down;
		logic                   char_open;
		logic [TIMER_W-1:0]     press_ticks;
		logic [TIMER_W-1:0]     idle_ticks;
		logic [MAX_SYMBOLS-1:0] symbol_bits;
		logic [SYM_CNT_W-1:0]   symbol_count;
	} state_t;

	typedef struct packed {
		logic [1:0]        symbol;
		logic              char_valid;
		logic [CODE_W-1:0] char_code;
		logic              space_valid;
	} result_t;

	localparam logic [CODE_W-1:0] LEN1_TAB [2]  = '{7'h45, 7'h54};
	localparam logic [CODE_W-1:0] LEN2_TAB [4]  = '{7'h49, 7'h41, 7'h4e, 7'h4d};
	localparam logic [CODE_W-1:0] LEN3_TAB [8]  = '{7'h53, 7'h55, 7'h52, 7'h57,
	                                                7'h44, 7'h4b, 7'h47, 7'h4f};
	localparam logic [CODE_W-1:0] LEN4_TAB [16] = '{7'h48, 7'h56, 7'h46, 7'h3f,
	                                                7'h4c, 7'h3f, 7'h50, 7'h4a,
	                                                7'h42, 7'h58, 7'h43, 7'h59,
	                                                7'h5a, 7'h51, 7'h3f, 7'h3f};

	function automatic logic [CODE_W-1:0] decode_letter(
		input logic [MAX_SYMBOLS-1:0] bits,
		input logic [SYM_CNT_W-1:0]   count
	);
		logic [CODE_W-1:0] code;
		case (count)
			SYM_CNT_W'(1): code = LEN1_TAB[bits[0]];
			SYM_CNT_W'(2): code = LEN2_TAB[bits[1:0]];
			SYM_CNT_W'(3): code = LEN3_TAB[bits[2:0]];
			SYM_CNT_W'(4): code = LEN4_TAB[bits[3:0]];
			default:       code = CODE_UNKNOWN;
		endcase
		return code;
	endfunction

	function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
		return (v == TIMER_MAX) ? TIMER_MAX : v + TIMER_W'(1);
	endfunction

endpackage

FILE: rtl/core/mkd_tick_if.sv
// mkd_tick_if: input channel, one beat per key tick
// no dependencies; it does not import mkd_pkg
interface mkd_tick_if;
	logic valid;
	logic ready;
	logic key_down;

	modport source (output valid, output key_down, input ready);
	modport sink   (input valid, input key_down, output ready);
endinterface

FILE: rtl/core/mkd_res_if.sv
// mkd_res_if: result channel, one beat per tick with symbol, character and space flags
// depends on mkd_pkg for the code width
interface mkd_res_if;
	import mkd_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        symbol;
	logic              char_valid;
	logic [CODE_W-1:0] char_code;
	logic              space_valid;

	modport source (output valid, output symbol, output char_valid, output char_code,
	                output space_valid, input ready);
	modport sink   (input valid, input symbol, input char_valid, input char_code,
	                input space_valid, output ready);
endinterface

FILE: rtl/core/mkd_step.sv
// mkd_step: next state and result for one key tick, purely combinational
// depends on mkd_pkg
module mkd_step import mkd_pkg::*; (
	input  cfg_t    cfg,
	input  state_t  cur,
	input  logic    key_down,
	output state_t  nxt,
	output result_t res
);

	logic dash;

	always_comb begin
		nxt  = cur;
		res  = '0;
		dash = 1'b0;

		nxt.idle_ticks = sat_inc(cur.idle_ticks);
		if (cur.key_was_down) begin
			nxt.press_ticks = sat_inc(cur.press_ticks);
		end

		// press
		if (key_down && !cur.key_was_down) begin
			nxt.key_was_down = 1'b1;
			nxt.press_ticks  = '0;
			nxt.char_open    = 1'b1;
		end

		// release
		if (!key_down && cur.key_was_down) begin
			dash             = (nxt.press_ticks >= cfg.dash_threshold);
			nxt.key_was_down = 1'b0;
			nxt.idle_ticks   = '0;
			res.symbol       = dash ? SYM_DASH : SYM_DOT;
			if (cur.symbol_count < SYM_CNT_W'(MAX_SYMBOLS)) begin
				nxt.symbol_bits  = {cur.symbol_bits[MAX_SYMBOLS-2:0], dash};
				nxt.symbol_count = cur.symbol_count + SYM_CNT_W'(1);
			end
		end

		// character gap
		if (nxt.char_open && !key_down && nxt.idle_ticks >= cfg.letter_gap) begin
			res.char_valid   = 1'b1;
			res.char_code    = decode_letter(nxt.symbol_bits, nxt.symbol_count);
			nxt.symbol_bits  = '0;
			nxt.symbol_count = '0;
			nxt.char_open    = 1'b0;
		end

		// word gap
		if (!nxt.char_open && !key_down && nxt.idle_ticks >= cfg.space_gap) begin
			res.space_valid = 1'b1;
			nxt.idle_ticks  = '0;
		end
	end

endmodule

FILE: rtl/core/morse_key_decoder.sv
// morse_key_decoder: top level, turns key ticks into dots, dashes, letters and spaces
// depends on mkd_pkg, mkd_tick_if, mkd_res_if and mkd_step
//
//   channel   dir  handshake            beat
//   tick      in   valid/ready          key_down
//   decode    out  valid/ready          symbol, char_valid, char_code, space_valid
//   wr_*      in   wr_en, no wait       wr_index, wr_data
//
// one tick per cycle sustained while result beats are taken; a tick's beat is taken into the
// input register and its result is offered from the result register. the decoder state
// advances as a tick moves from the input register into the result register. a stalled
// result register holds the input register, and tick.ready drops only when both hold a
// beat and the result beat is not taken.
// reset loads the register defaults and clears all decoder state.
module morse_key_decoder import mkd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	mkd_tick_if.sink             tick,
	mkd_res_if.source            decode,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_index,
	input  logic [TIMER_W-1:0]   wr_data
);

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	result_t res_s2;
	logic    key_s1;
	logic    vld_s1;
	logic    vld_s2;
	logic    out_free;
	logic    adv;

	assign out_free   = !vld_s2 || decode.ready;
	assign adv        = vld_s1 && out_free;
	assign tick.ready = !vld_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dash_threshold <= DASH_THRESHOLD_RST;
			cfg_q.letter_gap     <= LETTER_GAP_RST;
			cfg_q.space_gap      <= SPACE_GAP_RST;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_DASH_THRESHOLD: cfg_q.dash_threshold <= wr_data;
				REG_LETTER_GAP:     cfg_q.letter_gap     <= wr_data;
				REG_SPACE_GAP:      cfg_q.space_gap      <= wr_data;
				default: ;
			endcase
		end
	end

	mkd_step u_step (
		.cfg      (cfg_q),
		.cur      (state_q),
		.key_down (key_s1),
		.nxt      (state_nxt),
		.res      (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			if (tick.ready) begin
				vld_s1 <= tick.valid;
			end
			if (out_free) begin
				vld_s2 <= vld_s1;
			end
			if (adv) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			key_s1 <= tick.key_down;
		end
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	assign decode.valid       = vld_s2;
	assign decode.symbol      = res_s2.symbol;
	assign decode.char_valid  = res_s2.char_valid;
	assign decode.char_code   = res_s2.char_code;
	assign decode.space_valid = res_s2.space_valid;

endmodule

FILE: tb/morse_key_decoder_tb.sv
// morse_key_decoder_tb: self-checking bench for the morse key decoder
// depends on mkd_pkg, mkd_tick_if, mkd_res_if and the morse_key_decoder rtl
// directed table with register corners, then random keying under idling and stalls
module morse_key_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mkd_pkg::*;

	typedef enum {ROW_TICK, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic                 key;
		logic [REG_IDX_W-1:0] idx;
		logic [TIMER_W-1:0]   data;
		bit                   typed;
		result_t              want;
	} stim_row_t;

	localparam logic [REG_IDX_W-1:0] REG_IDX_SPARE = 2'd3;
	localparam int LIMIT_CYCLES  = 1000000;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 400;
	localparam int RAND_PHASES   = 5;
	localparam int PHASE_TICKS   = 200;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] wr_index;
	logic [TIMER_W-1:0]   wr_data;

	mkd_tick_if tick_ch();
	mkd_res_if  dec_ch();

	morse_key_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick_ch),
		.decode   (dec_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// decoder model state
	cfg_t                 key_cfg;
	logic                 was_down;
	logic                 char_pending;
	logic [TIMER_W-1:0]   press_len;
	logic [TIMER_W-1:0]   idle_len;
	logic [MAX_SYMBOLS-1:0] pattern;
	logic [SYM_CNT_W-1:0] pattern_len;

	result_t   owed_results[$];
	stim_row_t dir_rows[$];
	int        fails = 0;
	int        cycle_cnt = 0;
	bit        idle_on = 1'b1;
	bit        hold_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("** morse_key_decoder: FAILED **");
			$finish;
		end
	end

	function automatic logic [TIMER_W-1:0] timer_step(input logic [TIMER_W-1:0] v);
		return (v == '1) ? v : v + TIMER_W'(1);
	endfunction

	function automatic result_t decode_tick(input logic key);
		result_t r;
		logic    dash_bit;
		string   letters;
		int      sel;
		r = '0;
		idle_len = timer_step(idle_len);
		if (was_down)
			press_len = timer_step(press_len);
		if (key && !was_down) begin
			was_down = 1'b1;
			press_len = '0;
			char_pending = 1'b1;
		end
		if (!key && was_down) begin
			dash_bit = (press_len >= key_cfg.dash_threshold);
			was_down = 1'b0;
			idle_len = '0;
			r.symbol = dash_bit ? SYM_DASH : SYM_DOT;
			if (pattern_len < MAX_SYMBOLS) begin
				pattern = {pattern[MAX_SYMBOLS-2:0], dash_bit};
				pattern_len = pattern_len + SYM_CNT_W'(1);
			end
		end
		if (char_pending && !key && idle_len >= key_cfg.letter_gap) begin
			case (pattern_len)
				1: letters = "ET";
				2: letters = "IANM";
				3: letters = "SURWDKGO";
				4: letters = "HVF?L?PJBXCYZQ??";
				default: letters = "?";
			endcase
			sel = (pattern_len >= 1 && pattern_len <= 4) ?
				(int'(pattern) & ((1 << pattern_len) - 1)) : 0;
			r.char_valid = 1'b1;
			r.char_code = 7'(letters[sel]);
			pattern = '0;
			pattern_len = '0;
			char_pending = 1'b0;
		end
		if (!char_pending && !key && idle_len >= key_cfg.space_gap) begin
			r.space_valid = 1'b1;
			idle_len = '0;
		end
		return r;
	endfunction

	function automatic result_t beat(input logic [1:0] sym, input logic cv,
			input logic [CODE_W-1:0] code, input logic sv);
		return {sym, cv, code, sv};
	endfunction

	function automatic void add_row(input row_kind_t kind, input logic key,
			input logic [REG_IDX_W-1:0] idx, input logic [TIMER_W-1:0] data,
			input bit typed, input result_t want);
		stim_row_t r;
		r.kind = kind;
		r.key = key;
		r.idx = idx;
		r.data = data;
		r.typed = typed;
		r.want = want;
		dir_rows.push_back(r);
	endfunction

	task automatic push_tick(input logic key, input bit typed = 1'b0, input result_t want = '0);
		int      gap;
		result_t r;
		gap = idle_on ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.key_down <= key;
		do @(posedge clk); while (!tick_ch.ready);
		r = decode_tick(key);
		owed_results.push_back(typed ? want : r);
	endtask

	task automatic settle();
		tick_ch.valid <= 1'b0;
		while (owed_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [TIMER_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(posedge clk);
		case (idx)
			REG_DASH_THRESHOLD: key_cfg.dash_threshold = data;
			REG_LETTER_GAP:     key_cfg.letter_gap = data;
			REG_SPACE_GAP:      key_cfg.space_gap = data;
			default: ;
		endcase
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// mostly press/idle runs shaped around the current thresholds, some raw noise
	task automatic play_random(input int n_ticks, input bit with_hold);
		int sent, run, pick, dash, cgap, wgap;
		bit hold_pending;
		dash = int'(key_cfg.dash_threshold);
		cgap = int'(key_cfg.letter_gap);
		wgap = int'(key_cfg.space_gap);
		hold_pending = with_hold;
		sent = 0;
		while (sent < n_ticks) begin
			if (hold_pending && sent >= n_ticks / 2) begin
				hold_req = 1'b1;
				hold_pending = 1'b0;
			end
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				run = $urandom_range(1, 6);
				repeat (run) push_tick(1'($urandom_range(0, 1)));
			end else begin
				run = $urandom_range(1, 2 * dash + 1);
				repeat (run) push_tick(1'b1);
				sent += run;
				run = (pick < 6) ? $urandom_range(1, cgap) :
					$urandom_range(cgap, wgap + cgap + 2);
				repeat (run) push_tick(1'b0);
			end
			sent += run;
		end
	endtask

	// result side: per-beat stall draw, plus one long hold on request
	initial begin
		int      stall;
		result_t got;
		result_t want;
		stall = 0;
		dec_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (dec_ch.valid && dec_ch.ready) begin
				got = {dec_ch.symbol, dec_ch.char_valid, dec_ch.char_code, dec_ch.space_valid};
				if (owed_results.size() == 0) begin
					$display("%0t: unexpected decode beat, expected none, got %p", $time, got);
					fails++;
				end else begin
					want = owed_results.pop_front();
					if (got.symbol !== want.symbol || got.char_valid !== want.char_valid ||
							got.char_code !== want.char_code ||
							got.space_valid !== want.space_valid) begin
						$display("%0t: decode mismatch, expected %p, got %p", $time, want, got);
						fails++;
					end
				end
				stall = idle_on ? $urandom_range(0, 14) : 0;
			end
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				dec_ch.ready <= 1'b0;
				stall--;
			end else
				dec_ch.ready <= 1'b1;
		end
	end

	initial begin
		int ph;
		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.key_down = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_DASH_THRESHOLD;
		wr_data = '0;
		key_cfg.dash_threshold = 16'd200;
		key_cfg.letter_gap = 16'd400;
		key_cfg.space_gap = 16'd1000;
		was_down = 1'b0;
		char_pending = 1'b0;
		press_len = '0;
		idle_len = '0;
		pattern = '0;
		pattern_len = '0;

		// reset values, then zero registers, then small registers and a spare-index write, then a full pattern
		add_row(ROW_TICK, 1'b0, REG_DASH_THRESHOLD, '0, 1'b1, beat(SYM_NONE, 1'b0, '0, 1'b0));
		add_row(ROW_TICK, 1'b1, REG_DASH_THRESHOLD, '0, 1'b1, beat(SYM_NONE, 1'b0, '0, 1'b0));
		add_row(ROW_TICK, 1'b0, REG_DASH_THRESHOLD, '0, 1'b1, beat(SYM_DOT, 1'b0, '0, 1'b0));
		add_row(ROW_WRITE, 1'b0, REG_DASH_THRESHOLD, '0, 1'b0, '0);
		add_row(ROW_WRITE, 1'b0, REG_LETTER_GAP, '0, 1'b0, '0);
		add_row(ROW_WRITE, 1'b0, REG_SPACE_GAP, '0, 1'b0, '0);
		add_row(ROW_TICK, 1'b0, REG_DASH_THRESHOLD, '0, 1'b0, '0);
		add_row(ROW_TICK, 1'b1, REG_DASH_THRESHOLD, '0, 1'b1, beat(SYM_NONE, 1'b0, '0, 1'b0));
		add_row(ROW_TICK, 1'b0, REG_DASH_THRESHOLD, '0, 1'b1,
			beat(SYM_DASH, 1'b1, 7'("T"), 1'b1));
		add_row(ROW_WRITE, 1'b0, REG_DASH_THRESHOLD, 16'd2, 1'b0, '0);
		add_row(ROW_WRITE, 1'b0, REG_LETTER_GAP, 16'd1, 1'b0, '0);
		add_row(ROW_WRITE, 1'b0, REG_SPACE_GAP, 16'd1, 1'b0, '0);
		add_row(ROW_WRITE, 1'b0, REG_IDX_SPARE, '1, 1'b0, '0);
		add_row(ROW_TICK, 1'b1, REG_DASH_THRESHOLD, '0, 1'b0, '0);
		for (ph = 0; ph < 9; ph++) begin
			add_row(ROW_TICK, 1'b1, REG_DASH_THRESHOLD, '0, 1'b0, '0);
			add_row(ROW_TICK, 1'b0, REG_DASH_THRESHOLD, '0, 1'b0, '0);
		end
		add_row(ROW_TICK, 1'b0, REG_DASH_THRESHOLD, '0, 1'b1,
			beat(SYM_NONE, 1'b1, 7'("?"), 1'b1));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				settle();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else
				push_tick(dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);
		end

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			settle();
			write_reg(REG_DASH_THRESHOLD, TIMER_W'($urandom_range(1, 6)));
			write_reg(REG_LETTER_GAP, TIMER_W'($urandom_range(1, 8)));
			write_reg(REG_SPACE_GAP, TIMER_W'($urandom_range(1, 14)));
			idle_on = (ph != 0);
			play_random(PHASE_TICKS, ph == 2);
		end

		settle();
		if (fails == 0)
			$display("** morse_key_decoder: PASSED **");
		else
			$display("** morse_key_decoder: FAILED **");
		$finish;
	end

endmodule
